FILE: rtl/core/ppu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_pkg: shared definitions of the packed / planar pixel unpacker
// Register indexes, format codes, the item record that travels between the
// front and back parts, and the per-pixel decode function.
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Entries of the item queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd3;

  localparam logic [2:0] MODE_MONO2       = 3'd0;
  localparam logic [2:0] MODE_SCALED2     = 3'd1;
  localparam logic [2:0] MODE_NIBBLE      = 3'd2;
  localparam logic [2:0] MODE_NIBBLE_BASE = 3'd3;
  localparam logic [2:0] MODE_PLANAR      = 3'd4;

  localparam logic [2:0]  FORMAT_MODE_RST  = MODE_NIBBLE;
  localparam logic [7:0]  PALETTE_BASE_RST = 8'd0;
  localparam logic [10:0] ROW_WIDTH_RST    = 11'd320;
  localparam logic [10:0] ROW_COUNT_RST    = 11'd200;

  localparam logic [7:0] MASK_HI    = 8'hF0;
  localparam logic [7:0] MASK_LO    = 8'h0F;
  localparam logic [7:0] MONO_MID   = 8'h7F;
  localparam logic [7:0] MONO_WHITE = 8'hFF;
  localparam logic [7:0] MONO_BLACK = 8'h00;

  // Index of the final pixel of a byte, per format
  localparam logic [2:0] LAST_K_2BPP   = 3'd3;
  localparam logic [2:0] LAST_K_4BPP   = 3'd1;
  localparam logic [2:0] LAST_K_PLANAR = 3'd7;

  typedef struct packed {
    logic [2:0]      mode;
    logic [2:0]      last_k;
    logic [4:0][7:0] planes;
  } ppu_item_t;

  typedef struct packed {
    logic [7:0]  palette_base;
    logic [10:0] row_width;
    logic [10:0] row_count;
  } ppu_cfg_t;

  // Decode pixel k (leftmost is 0) of one item
  function automatic logic [7:0] pixel_of(input logic [2:0] mode,
                                          input logic [4:0][7:0] planes,
                                          input logic [2:0] k,
                                          input logic [7:0] base);
    logic [7:0] b;
    logic [7:0] shifted;
    logic [1:0] v2;
    logic [3:0] nib;
    logic [2:0] bi;
    logic [7:0] px;
    b       = planes[0];
    shifted = b << {k[1:0], 1'b0};
    v2      = shifted[7:6];
    nib     = (k == 3'd0) ? 4'((b & MASK_HI) >> 4) : 4'(b & MASK_LO);
    bi      = 3'd7 - k;
    case (mode)
      MODE_MONO2: begin
        px = v2[1] ? MONO_MID : (v2[0] ? MONO_BLACK : MONO_WHITE);
      end
      MODE_SCALED2: begin
        px = {v2, 6'd0};
      end
      MODE_NIBBLE: begin
        px = {4'd0, nib};
      end
      MODE_NIBBLE_BASE: begin
        px = {4'd0, nib} + base;
      end
      default: begin
        px = {3'b000, planes[4][bi], planes[3][bi], planes[2][bi],
              planes[1][bi], planes[0][bi]};
      end
    endcase
    return px;
  endfunction

endpackage

FILE: rtl/core/ppu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_front: input side of the pixel unpacker
// Accepts items, tags each with its format and pixel count, drops items of
// unused formats, and holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
module ppu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_plane0_byte,
  input  logic [7:0]           in_plane1_byte,
  input  logic [7:0]           in_plane2_byte,
  input  logic [7:0]           in_plane3_byte,
  input  logic [7:0]           in_plane4_byte,
  input  logic [2:0]           format_mode,
  input  logic                 q_pop,
  output logic                 q_valid,
  output ppu_pkg::ppu_item_t   q_head
);

  localparam int PTR_W = (ppu_pkg::QUEUE_DEPTH > 1) ? $clog2(ppu_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ppu_pkg::QUEUE_DEPTH + 1);

  ppu_pkg::ppu_item_t entry_r [ppu_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               wr_en;
  logic               rd_en;
  ppu_pkg::ppu_item_t item;

  assign full    = (count_r == CNT_W'(ppu_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_head  = entry_r[rd_ptr_r];
  assign rd_en   = q_pop && q_valid;

  // Unused formats are taken and dropped without a queue entry
  assign wr_en = push && !full && (format_mode <= ppu_pkg::MODE_PLANAR);

  always_comb begin
    item.mode   = format_mode;
    item.planes = {in_plane4_byte, in_plane3_byte, in_plane2_byte,
                   in_plane1_byte, in_plane0_byte};
    if (format_mode <= ppu_pkg::MODE_SCALED2) begin
      item.last_k = ppu_pkg::LAST_K_2BPP;
    end else if (format_mode <= ppu_pkg::MODE_NIBBLE_BASE) begin
      item.last_k = ppu_pkg::LAST_K_4BPP;
    end else begin
      item.last_k = ppu_pkg::LAST_K_PLANAR;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_en ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (!wr_en && rd_en) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= item;
    end
  end

endmodule

FILE: rtl/core/ppu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_back: pixel serializer of the pixel unpacker
// Emits one pixel per cycle from the queue head while the output register is free
// or being popped, tracks column and row, and holds each pixel in an output
// register until it is popped.
module ppu_back #(
  parameter int MAX_WIDTH  = ppu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ppu_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ppu_pkg::ppu_cfg_t  cfg,
  input  logic               q_valid,
  input  ppu_pkg::ppu_item_t q_head,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_pixel_value,
  output logic               out_row_end,
  output logic               out_frame_end,
  output logic               out_last
);

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WD_RAW  = $clog2(MAX_WIDTH + 1);
  localparam int HT_RAW  = $clog2(MAX_HEIGHT + 1);
  localparam int WD_W    = (WD_RAW > 11) ? WD_RAW : 11;
  localparam int HT_W    = (HT_RAW > 11) ? HT_RAW : 11;

  logic [COL_W-1:0] col_r, col_nxt, col_eff;
  logic [ROW_W-1:0] row_r, row_nxt, row_eff;
  logic [2:0]       k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       pix_r;
  logic             re_r, fe_r, last_r;

  logic [WD_W-1:0]  rw, w_eff;
  logic [HT_W-1:0]  rc, h_eff;
  logic [HT_W-1:0]  row_tmp, row_inc;
  logic             first, wrap_col, re, fe, stop, last_pix, emit;
  logic [7:0]       pix;

  // Clamp dimensions: zero acts as one, oversize acts as the maximum
  always_comb begin
    rw = WD_W'(cfg.row_width);
    rc = HT_W'(cfg.row_count);
    if (rw == '0) begin
      w_eff = WD_W'(1);
    end else if (rw > WD_W'(MAX_WIDTH)) begin
      w_eff = WD_W'(MAX_WIDTH);
    end else begin
      w_eff = rw;
    end
    if (rc == '0) begin
      h_eff = HT_W'(1);
    end else if (rc > HT_W'(MAX_HEIGHT)) begin
      h_eff = HT_W'(MAX_HEIGHT);
    end else begin
      h_eff = rc;
    end
  end

  always_comb begin
    first    = (k_r == 3'd0);
    // Fold counters left past the bounds by a register change
    wrap_col = first && (WD_W'(col_r) >= w_eff);
    col_eff  = wrap_col ? '0 : col_r;
    row_tmp  = HT_W'(row_r) + (wrap_col ? HT_W'(1) : '0);
    row_eff  = (first && (row_tmp >= h_eff)) ? '0 : ROW_W'(row_tmp);
    row_inc  = HT_W'(row_eff) + HT_W'(1);

    re       = ((WD_W'(col_eff) + WD_W'(1)) == w_eff);
    fe       = re && (row_inc == h_eff);
    stop     = (q_head.mode == ppu_pkg::MODE_PLANAR) ? fe : re;
    last_pix = stop || (k_r == q_head.last_k);
    pix      = ppu_pkg::pixel_of(q_head.mode, q_head.planes, k_r, cfg.palette_base);

    emit     = q_valid && (!out_valid_r || pop);
    q_pop    = emit && last_pix;

    k_nxt         = k_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !pop;
    if (emit) begin
      out_valid_nxt = 1'b1;
      k_nxt         = last_pix ? 3'd0 : 3'(k_r + 3'd1);
      if (re) begin
        col_nxt = '0;
        row_nxt = fe ? '0 : ROW_W'(row_inc);
      end else begin
        col_nxt = COL_W'(col_eff + 1'b1);
        row_nxt = row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix_r  <= pix;
      re_r   <= re;
      fe_r   <= fe;
      last_r <= last_pix;
    end
  end

  assign empty           = !out_valid_r;
  assign out_pixel_value = pix_r;
  assign out_row_end     = re_r;
  assign out_frame_end   = fe_r;
  assign out_last        = last_r;

endmodule

FILE: rtl/core/packed_planar_pixel_unpacker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_planar_pixel_unpacker: packed / planar bitmap byte to pixel stream
// Top level: configuration registers, front (accept and queue) and back
// (pixel serializer with row and frame tracking).
// ----------------------------------------------------------------------------
// Each item pushed in is one packed byte (plane0) or five plane bytes and
// leaves as up to eight 8-bit pixels, leftmost first, one result per pixel,
// at one pixel per clock while the output is free or popped: a 2-bit format
// item gives 4 pixels, a nibble format item 2, a planar item 8, fewer where
// a packed byte is clipped at the row end or a planar byte runs into the
// image end. The pixel serializer in the back part sets that rate; the
// front takes items every cycle into a four-entry queue until it fills,
// and items of an unused format are taken and dropped with no result.
// out_last marks the final pixel of an item, out_row_end and out_frame_end
// the last pixel of a row and of the image. A row width or count of zero
// acts as one and a value above MAX_WIDTH / MAX_HEIGHT acts as that
// maximum. Write configuration only while no result is outstanding.
module packed_planar_pixel_unpacker #(
  parameter int MAX_WIDTH  = ppu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ppu_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     in_plane0_byte,
  input  logic [7:0]                     in_plane1_byte,
  input  logic [7:0]                     in_plane2_byte,
  input  logic [7:0]                     in_plane3_byte,
  input  logic [7:0]                     in_plane4_byte,
  // result items
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_pixel_value,
  output logic                           out_row_end,
  output logic                           out_frame_end,
  output logic                           out_last
);

  logic [2:0]         format_mode_r;
  logic [7:0]         palette_base_r;
  logic [10:0]        row_width_r;
  logic [10:0]        row_count_r;
  ppu_pkg::ppu_cfg_t  cfg;
  logic               q_valid;
  logic               q_pop;
  ppu_pkg::ppu_item_t q_head;

  // Configuration registers; every index of the port maps to a register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_mode_r  <= ppu_pkg::FORMAT_MODE_RST;
      palette_base_r <= ppu_pkg::PALETTE_BASE_RST;
      row_width_r    <= ppu_pkg::ROW_WIDTH_RST;
      row_count_r    <= ppu_pkg::ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ppu_pkg::REG_FORMAT_MODE:  format_mode_r  <= cfg_wdata[2:0];
        ppu_pkg::REG_PALETTE_BASE: palette_base_r <= cfg_wdata[7:0];
        ppu_pkg::REG_ROW_WIDTH:    row_width_r    <= cfg_wdata[10:0];
        ppu_pkg::REG_ROW_COUNT:    row_count_r    <= cfg_wdata[10:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.palette_base = palette_base_r;
  assign cfg.row_width    = row_width_r;
  assign cfg.row_count    = row_count_r;

  // Front: accept, classify, queue
  ppu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_plane0_byte (in_plane0_byte),
    .in_plane1_byte (in_plane1_byte),
    .in_plane2_byte (in_plane2_byte),
    .in_plane3_byte (in_plane3_byte),
    .in_plane4_byte (in_plane4_byte),
    .format_mode    (format_mode_r),
    .q_pop          (q_pop),
    .q_valid        (q_valid),
    .q_head         (q_head)
  );

  // Back: serialize pixels, advance column and row, hold output
  ppu_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_value (out_pixel_value),
    .out_row_end     (out_row_end),
    .out_frame_end   (out_frame_end),
    .out_last        (out_last)
  );

endmodule

FILE: rtl/core/ppu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_checker: port-level checks of the pixel unpacker
// Watches the result port over time and flags ordering and flag slips.
// ----------------------------------------------------------------------------
module ppu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_pixel_value,
  input logic       out_row_end,
  input logic       out_frame_end,
  input logic       out_last
);

  // Hold a waiting result until it is popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pixel_value) && $stable(out_last)))
    else $error("result changed while waiting");

  // The rest of an item follows without a gap once a pixel is taken
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last) |=> !empty)
    else $error("gap inside an item");

  // The image end is always a row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_end) |-> out_row_end)
    else $error("frame end without row end");

  // Nothing of an item follows the image end
  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_end) |-> out_last)
    else $error("frame end not last of item");

endmodule

bind packed_planar_pixel_unpacker ppu_checker u_ppu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .empty           (empty),
  .pop             (pop),
  .out_pixel_value (out_pixel_value),
  .out_row_end     (out_row_end),
  .out_frame_end   (out_frame_end),
  .out_last        (out_last)
);
